@@ rtl/core/scs_pkg.sv @@
package scs_pkg;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int ERR_W   = 4;
    localparam int WORD_W  = 16;
    localparam int SIZE_W  = 4;
    localparam int STATE_W = 5;

    // command codes on the input tuser
    localparam logic [CMD_W-1:0] CMD_NEXT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_2B   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_34   = 2'd2;

    // parser states
    localparam logic [STATE_W-1:0] ST_IDLE   = 5'd0;
    localparam logic [STATE_W-1:0] ST_AVPP   = 5'd1;
    localparam logic [STATE_W-1:0] ST_AHPP   = 5'd2;
    localparam logic [STATE_W-1:0] ST_D1     = 5'd3;
    localparam logic [STATE_W-1:0] ST_D106   = 5'd4;
    localparam logic [STATE_W-1:0] ST_D107   = 5'd5;
    localparam logic [STATE_W-1:0] ST_D103   = 5'd6;
    localparam logic [STATE_W-1:0] ST_D2LEN  = 5'd7;
    localparam logic [STATE_W-1:0] ST_D2CODE = 5'd8;
    localparam logic [STATE_W-1:0] ST_D3LEN  = 5'd9;
    localparam logic [STATE_W-1:0] ST_D3CODE = 5'd10;
    localparam logic [STATE_W-1:0] ST_PITCH0 = 5'd11;
    localparam logic [STATE_W-1:0] ST_PITCH1 = 5'd12;
    localparam logic [STATE_W-1:0] ST_WHI    = 5'd13;
    localparam logic [STATE_W-1:0] ST_WLO    = 5'd14;
    localparam logic [STATE_W-1:0] ST_LHI    = 5'd15;
    localparam logic [STATE_W-1:0] ST_LLO    = 5'd16;
    localparam logic [STATE_W-1:0] ST_SKIP   = 5'd17;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE   = 4'd0;
    localparam logic [ERR_W-1:0] ERR_34     = 4'd1;
    localparam logic [ERR_W-1:0] ERR_2B     = 4'd2;
    localparam logic [ERR_W-1:0] ERR_D1     = 4'd3;
    localparam logic [ERR_W-1:0] ERR_D106   = 4'd4;
    localparam logic [ERR_W-1:0] ERR_D107   = 4'd5;
    localparam logic [ERR_W-1:0] ERR_D103   = 4'd6;
    localparam logic [ERR_W-1:0] ERR_D2     = 4'd7;
    localparam logic [ERR_W-1:0] ERR_D203   = 4'd8;
    localparam logic [ERR_W-1:0] ERR_D204   = 4'd9;
    localparam logic [ERR_W-1:0] ERR_D20429 = 4'd10;
    localparam logic [ERR_W-1:0] ERR_D3     = 4'd11;

    // configuration register indexes
    localparam logic CFG_AHPP = 1'b0;
    localparam logic CFG_AVPP = 1'b1;

    localparam logic [BYTE_W-1:0] AHPP_RESET = 8'hC0;
    localparam logic [BYTE_W-1:0] AVPP_RESET = 8'hC4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd10;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_byte;
    } beat_t;

    typedef struct packed {
        logic              sequence_done;
        logic [ERR_W-1:0]  error_code;
        logic [WORD_W-1:0] page_width;
        logic [WORD_W-1:0] page_length;
        logic [SIZE_W-1:0] point_size;
        logic [BYTE_W-1:0] horiz_position;
        logic [BYTE_W-1:0] spaces_to_insert;
        logic              spaces_valid;
    } result_t;

    // characters per inch to point size
    function automatic logic [SIZE_W-1:0] pitch_to_size(input logic [BYTE_W-1:0] cpi);
        logic [SIZE_W-1:0] sz;
        unique case (cpi)
            8'd5:    sz = 4'd14;
            8'd10:   sz = 4'd10;
            8'd12:   sz = 4'd9;
            8'd13:   sz = 4'd8;
            8'd15:   sz = 4'd7;
            8'd16:   sz = 4'd6;
            8'd18:   sz = 4'd5;
            8'd20:   sz = 4'd4;
            default: sz = SIZE_RESET;
        endcase
        return sz;
    endfunction

endpackage

@@ rtl/core/scs_in_stage.sv @@
module scs_in_stage
    import scs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  beat_t in_beat,
    output logic  out_valid,
    input  logic  out_ready,
    output beat_t out_beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;
    logic  in_take;

    assign in_ready = !valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        if (in_take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            beat_reg <= in_beat;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

@@ rtl/core/scs_parser.sv @@
module scs_parser
    import scs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  beat_t             in_beat,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_result
);

    logic [BYTE_W-1:0]  ahpp_code_reg;
    logic [BYTE_W-1:0]  avpp_code_reg;

    logic [STATE_W-1:0] state_reg,    state_next;
    logic [BYTE_W-1:0]  skip_reg,     skip_next;
    logic [BYTE_W-1:0]  held_reg,     held_next;
    logic [BYTE_W-1:0]  acc_reg,      acc_next;
    logic [WORD_W-1:0]  width_reg,    width_next;
    logic [WORD_W-1:0]  length_reg,   length_next;
    logic [SIZE_W-1:0]  size_reg,     size_next;
    logic [BYTE_W-1:0]  pos_reg,      pos_next;

    logic               out_valid_reg;
    result_t            out_reg;
    result_t            res_next;

    logic               adv;
    logic [BYTE_W-1:0]  b;
    logic [BYTE_W-1:0]  held_len;
    logic               done;
    logic [ERR_W-1:0]   err;
    logic [BYTE_W-1:0]  sp;
    logic               spv;
    logic               do_skip;
    logic [BYTE_W-1:0]  skip_len;

    assign in_ready = !out_valid_reg || out_ready;
    assign adv      = in_valid && in_ready;
    assign b        = in_beat.data_byte;
    // count byte minus 2, floored at zero
    assign held_len = (held_reg > 8'd2) ? (held_reg - 8'd2) : '0;

    always_comb
    begin
        state_next  = state_reg;
        skip_next   = skip_reg;
        held_next   = held_reg;
        acc_next    = acc_reg;
        width_next  = width_reg;
        length_next = length_reg;
        size_next   = size_reg;
        pos_next    = pos_reg;
        done        = 1'b0;
        err         = ERR_NONE;
        sp          = '0;
        spv         = 1'b0;
        do_skip     = 1'b0;
        skip_len    = '0;

        priority if (in_beat.cmd == CMD_34)
        begin
            // AVPP takes priority when both codes match
            priority if (b == avpp_code_reg)
            begin
                state_next = ST_AVPP;
            end
            else if (b == ahpp_code_reg)
            begin
                state_next = ST_AHPP;
            end
            else
            begin
                err = ERR_34;
            end
        end
        else if (in_beat.cmd == CMD_2B)
        begin
            unique case (b)
                8'hD1:   state_next = ST_D1;
                8'hD2:   state_next = ST_D2LEN;
                8'hD3:   state_next = ST_D3LEN;
                8'hC8:
                begin
                    do_skip  = 1'b1;
                    skip_len = 8'd3;
                end
                default: err = ERR_2B;
            endcase
        end
        else
        begin
            unique case (state_reg)
                ST_AVPP:
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
                ST_AHPP:
                begin
                    sp         = (pos_reg > b) ? b : (b - pos_reg);
                    spv        = 1'b1;
                    pos_next   = b;
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
                ST_D1:
                begin
                    unique case (b)
                        8'h06:   state_next = ST_D106;
                        8'h07:   state_next = ST_D107;
                        8'h03:   state_next = ST_D103;
                        default: err = ERR_D1;
                    endcase
                end
                ST_D106:
                begin
                    if (b == 8'h01)
                    begin
                        do_skip  = 1'b1;
                        skip_len = 8'd4;
                    end
                    else
                    begin
                        err = ERR_D106;
                    end
                end
                ST_D107:
                begin
                    if (b == 8'h05)
                    begin
                        do_skip  = 1'b1;
                        skip_len = 8'd5;
                    end
                    else
                    begin
                        err = ERR_D107;
                    end
                end
                ST_D103:
                begin
                    if (b == 8'h81)
                    begin
                        do_skip  = 1'b1;
                        skip_len = 8'd1;
                    end
                    else
                    begin
                        err = ERR_D103;
                    end
                end
                ST_D2LEN:
                begin
                    held_next  = b;
                    state_next = ST_D2CODE;
                end
                ST_D2CODE:
                begin
                    unique case (b)
                        8'h01, 8'h03, 8'h0D, 8'h48, 8'h49, 8'h4C, 8'h85, 8'h11:
                        begin
                            do_skip  = 1'b1;
                            skip_len = held_len;
                        end
                        8'h40:   state_next = ST_WHI;
                        default:
                        begin
                            priority if (held_reg == 8'h03)
                            begin
                                if (b == 8'h45 || b == 8'h07 || b == 8'h09)
                                begin
                                    do_skip  = 1'b1;
                                    skip_len = 8'd1;
                                end
                                else
                                begin
                                    err = ERR_D203;
                                end
                            end
                            else if (held_reg == 8'h04)
                            begin
                                priority if (b == 8'h15)
                                begin
                                    do_skip  = 1'b1;
                                    skip_len = 8'd2;
                                end
                                else if (b == 8'h29)
                                begin
                                    state_next = ST_PITCH0;
                                end
                                else
                                begin
                                    err = ERR_D204;
                                end
                            end
                            else
                            begin
                                err = ERR_D2;
                            end
                        end
                    endcase
                end
                ST_D3LEN:
                begin
                    held_next  = b;
                    state_next = ST_D3CODE;
                end
                ST_D3CODE:
                begin
                    if (b == 8'hF6)
                    begin
                        do_skip  = 1'b1;
                        skip_len = held_len;
                    end
                    else
                    begin
                        err = ERR_D3;
                    end
                end
                ST_PITCH0:
                begin
                    if (b == 8'h00)
                    begin
                        state_next = ST_PITCH1;
                    end
                    else
                    begin
                        err = ERR_D20429;
                    end
                end
                ST_PITCH1:
                begin
                    size_next  = pitch_to_size(b);
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
                ST_WHI:
                begin
                    acc_next   = b;
                    state_next = ST_WLO;
                end
                ST_WLO:
                begin
                    width_next = {acc_reg, b};
                    state_next = ST_LHI;
                end
                ST_LHI:
                begin
                    acc_next   = b;
                    state_next = ST_LLO;
                end
                ST_LLO:
                begin
                    length_next = {acc_reg, b};
                    done        = 1'b1;
                    state_next  = ST_IDLE;
                end
                ST_SKIP:
                begin
                    skip_next = skip_reg - 8'd1;
                    if (skip_reg == 8'd1)
                    begin
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end

        if (err != ERR_NONE)
        begin
            done       = 1'b1;
            state_next = ST_IDLE;
        end
        else if (do_skip)
        begin
            if (skip_len == '0)
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            else
            begin
                skip_next  = skip_len;
                state_next = ST_SKIP;
            end
        end

        res_next.sequence_done    = done;
        res_next.error_code       = err;
        res_next.page_width       = width_next;
        res_next.page_length      = length_next;
        res_next.point_size       = size_next;
        res_next.horiz_position   = pos_next;
        res_next.spaces_to_insert = sp;
        res_next.spaces_valid     = spv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ahpp_code_reg <= AHPP_RESET;
            avpp_code_reg <= AVPP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AHPP: ahpp_code_reg <= cfg_data;
                CFG_AVPP: avpp_code_reg <= cfg_data;
                default:  ahpp_code_reg <= ahpp_code_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            skip_reg   <= '0;
            held_reg   <= '0;
            acc_reg    <= '0;
            width_reg  <= '0;
            length_reg <= '0;
            size_reg   <= SIZE_RESET;
            pos_reg    <= '0;
        end
        else if (adv)
        begin
            state_reg  <= state_next;
            skip_reg   <= skip_next;
            held_reg   <= held_next;
            acc_reg    <= acc_next;
            width_reg  <= width_next;
            length_reg <= length_next;
            size_reg   <= size_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

`ifndef SYNTH
    a_spaces_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.spaces_valid |-> out_reg.sequence_done)
        else $error("spaces result without end of sequence");

    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.error_code != ERR_NONE) |-> out_reg.sequence_done)
        else $error("error reported without end of sequence");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SKIP |-> skip_reg != '0)
        else $error("skip state with empty count");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        adv && done |=> state_reg == ST_IDLE)
        else $error("parser not idle after sequence end");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("processed beat produced no result");
`endif

endmodule

@@ rtl/core/scs_control_sequence_parser_top.sv @@
// SCS control sequence parser.
// Input stream (s_axis): one byte of the printer data stream per beat, sent
// after an upstream stage has found a 0x2B or 0x34 introducer. tuser carries
// the command (0 next byte, 1 first byte after 0x2B, 2 first byte after 0x34).
// Output stream (m_axis): exactly one result beat per input beat, in order.
// tlast marks the byte that completes or aborts a sequence; tdata carries the
// error code and the current page, size and position values; tuser flags an
// AHPP spaces count.
// Config: cfg_we writes AHPP (index 0) or AVPP (index 1) sub-command codes;
// write only while no beat is in flight.
// Path: input register, then the parse step into the result register.
// Throughput: one beat per cycle while m_axis_tready is high.
// Reset: empties both registers, parser idle, stores cleared, point size 10,
// codes back to 0xC0 / 0xC4. When m_axis_tready is low the result holds and
// an empty input register takes one more beat before s_axis_tready drops.
module scs_control_sequence_parser_top
    import scs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // data_byte
    input  logic [1:0]        s_axis_tuser,   // cmd
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // error_code[3:0], page_width[19:4], page_length[35:20], point_size[39:36],
    // horiz_position[47:40], spaces_to_insert[55:48]
    output logic [55:0]       m_axis_tdata,
    output logic              m_axis_tlast,   // sequence_done
    output logic [0:0]        m_axis_tuser    // spaces_valid
);

    beat_t   s_beat;
    beat_t   p_beat;
    logic    p_valid;
    logic    p_ready;
    result_t res;

    assign s_beat.cmd       = s_axis_tuser;
    assign s_beat.data_byte = s_axis_tdata;

    scs_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_beat   (s_beat),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_beat  (p_beat)
    );

    scs_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (p_valid),
        .in_ready   (p_ready),
        .in_beat    (p_beat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (res)
    );

    assign m_axis_tdata = {res.spaces_to_insert, res.horiz_position, res.point_size,
                           res.page_length, res.page_width, res.error_code};
    assign m_axis_tlast = res.sequence_done;
    assign m_axis_tuser = res.spaces_valid;

endmodule
